// ===== src/pip_pkg.sv =====
// shared types, widths and constants for the point-in-region test
package pip_pkg;

    localparam int COORD_BITS    = 21;
    localparam int POS_FRAC_BITS = 10;
    localparam int ROT_FRAC_BITS = COORD_BITS - 2;

    localparam int W      = COORD_BITS;
    localparam int DW     = W + 1;              // point minus centre
    localparam int PW     = W + DW;             // rotation times delta
    localparam int SW     = PW + 2;             // sum of three products
    localparam int CW     = PW + 1;             // cross product component
    localparam int MW     = CW - 1;             // its magnitude
    localparam int CLO    = DW;                 // low split of magnitude
    localparam int CHI    = MW - CLO;           // high split of magnitude
    localparam int UQW    = 2 * W - 1;          // one axis entry squared
    localparam int UUW    = 2 * W + 1;          // squared axis length
    localparam int UHW    = UUW - W;            // high split of uu
    localparam int RRW    = 2 * W;              // radius squared
    localparam int DQW    = 2 * DW - 1;         // one delta squared
    localparam int DDW    = 2 * DW + 2;         // squared distance
    localparam int LIMW   = W + ROT_FRAC_BITS;  // box limit
    localparam int LW     = SW + ROT_FRAC_BITS + 1;
    localparam int HW     = W + UUW;
    localparam int AW     = 2 * MW + 2;
    localparam int BBW    = RRW + UUW + 1;
    localparam int W3     = 3 * W;
    localparam int W2     = 2 * W;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    localparam logic [W3-1:0] ROT0_RST = W3'(1) << ROT_FRAC_BITS;
    localparam logic [W3-1:0] ROT1_RST = W3'(1) << (ROT_FRAC_BITS + W);
    localparam logic [W3-1:0] ROT2_RST = W3'(1) << (ROT_FRAC_BITS + 2 * W);
    localparam logic [W3-1:0] EXT_RST  = (W3'(1) << POS_FRAC_BITS)
                                       | (W3'(1) << (POS_FRAC_BITS + W))
                                       | (W3'(1) << (POS_FRAC_BITS + 2 * W));
    localparam logic [W2-1:0] RH_RST   = (W2'(1) << (POS_FRAC_BITS - 1))
                                       | (W2'(1) << (POS_FRAC_BITS + W));

    typedef enum logic [1:0] {
        SHAPE_BOX    = 2'd0,
        SHAPE_CYL    = 2'd1,
        SHAPE_SPHERE = 2'd2
    } shape_t;

    typedef enum logic [2:0] {
        CFG_SHAPE  = 3'd0,
        CFG_CENTER = 3'd1,
        CFG_ROT0   = 3'd2,
        CFG_ROT1   = 3'd3,
        CFG_ROT2   = 3'd4,
        CFG_EXTENT = 3'd5,
        CFG_RH     = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic [1:0]            shape;
        logic [W3-1:0]         center;
        logic [2:0][W3-1:0]    rot;
        logic [W3-1:0]         extent;
        logic [W2-1:0]         rh;
    } cfg_t;

    typedef logic [2:0][DW-1:0] delta_vec_t;

    typedef struct packed {
        logic       valid;
        delta_vec_t data;
    } push_t;

endpackage

// ===== src/pip_if.sv =====
// point and result channel interfaces
interface pip_point_if;
    import pip_pkg::*;
    logic                valid;
    logic                ready;
    logic signed [W-1:0] point_x;
    logic signed [W-1:0] point_y;
    logic signed [W-1:0] point_z;
    modport source (output valid, point_x, point_y, point_z, input ready);
    modport sink   (input valid, point_x, point_y, point_z, output ready);
endinterface

interface pip_res_if;
    logic valid;
    logic ready;
    logic inside_res;
    modport source (output valid, inside_res, input ready);
    modport sink   (input valid, inside_res, output ready);
endinterface

// ===== src/point_in_oriented_primitive_unit.sv =====
// an accepted transaction is written into the queue, then passes the stage 1 to 4 registers
// and the result register until its result is valid, with the queue empty and the result side ready
// throughput: one point per cycle; the back pipeline stalls as a whole on the result side
// a 4-entry queue lets the input side keep accepting while the back is stalled
// reset clears all valid state and loads the default region (unit box at origin)
module point_in_oriented_primitive_unit (
    input  logic                   clk,
    input  logic                   rst_n,
    pip_point_if.sink              pt,
    pip_res_if.source              res,
    input  logic                   cfg_we,
    input  logic [2:0]             cfg_idx,
    input  logic [pip_pkg::W3-1:0] cfg_wdata
);
    import pip_pkg::*;

    cfg_t       cfg;
    push_t      push;
    logic       full;
    logic       empty;
    logic       pop;
    delta_vec_t head;

    pip_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .pt        (pt),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg),
        .push      (push),
        .full      (full)
    );

    pip_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .pop      (pop),
        .pop_data (head),
        .empty    (empty)
    );

    pip_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .head  (head),
        .empty (empty),
        .pop   (pop),
        .res   (res)
    );

endmodule

// ===== src/pip_fifo.sv =====
// short queue of centred points between front and back
module pip_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  pip_pkg::push_t     push,
    output logic               full,
    input  logic               pop,
    output pip_pkg::delta_vec_t pop_data,
    output logic               empty
);
    import pip_pkg::*;

    delta_vec_t       mem_reg [QDEPTH];
    logic [QAW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCW-1:0]   count_reg, count_next;
    logic             do_push;

    assign full     = (count_reg == QCW'(QDEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push.valid && !full;
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QAW'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QAW'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push.data;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCW'(QDEPTH)) else $error("queue count past depth");
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != '0) else $error("pop from empty queue");
    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("push lost");
    a_pop_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !do_push) |=> count_reg == $past(count_reg) - 1'b1)
        else $error("pop lost");

endmodule

// ===== src/pip_front.sv =====
// register file and point centring in front of the queue
module pip_front (
    input  logic                  clk,
    input  logic                  rst_n,
    pip_point_if.sink             pt,
    input  logic                  cfg_we,
    input  logic [2:0]            cfg_idx,
    input  logic [pip_pkg::W3-1:0] cfg_wdata,
    output pip_pkg::cfg_t         cfg,
    output pip_pkg::push_t        push,
    input  logic                  full
);
    import pip_pkg::*;

    cfg_t cfg_reg, cfg_next;
    logic signed [W-1:0] q [3];

    assign cfg = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_idx))
                CFG_SHAPE:  cfg_next.shape  = cfg_wdata[1:0];
                CFG_CENTER: cfg_next.center = cfg_wdata;
                CFG_ROT0:   cfg_next.rot[0] = cfg_wdata;
                CFG_ROT1:   cfg_next.rot[1] = cfg_wdata;
                CFG_ROT2:   cfg_next.rot[2] = cfg_wdata;
                CFG_EXTENT: cfg_next.extent = cfg_wdata;
                CFG_RH:     cfg_next.rh     = cfg_wdata[W2-1:0];
                default:    cfg_next        = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.shape  <= 2'(SHAPE_BOX);
            cfg_reg.center <= '0;
            cfg_reg.rot[0] <= ROT0_RST;
            cfg_reg.rot[1] <= ROT1_RST;
            cfg_reg.rot[2] <= ROT2_RST;
            cfg_reg.extent <= EXT_RST;
            cfg_reg.rh     <= RH_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // point minus centre, one slice per axis
    assign q[0] = pt.point_x;
    assign q[1] = pt.point_y;
    assign q[2] = pt.point_z;

    always_comb
    begin
        push.valid = pt.valid;
        for (int i = 0; i < 3; i++)
        begin
            push.data[i] = DW'(q[i]) - DW'($signed(cfg_reg.center[i*W +: W]));
        end
    end

    assign pt.ready = !full;

endmodule

// ===== src/pip_back.sv =====
// pipelined box, cylinder and sphere evaluation behind the queue
module pip_back (
    input  logic                clk,
    input  logic                rst_n,
    input  pip_pkg::cfg_t       cfg,
    input  pip_pkg::delta_vec_t head,
    input  logic                empty,
    output logic                pop,
    pip_res_if.source           res
);
    import pip_pkg::*;

    logic en;
    logic v1_reg, v2_reg, v3_reg, v4_reg, out_v_reg;
    logic out_in_reg, out_in_next;

    logic signed [W-1:0]  rot [3][3];
    logic signed [DW-1:0] d [3];
    logic [W-1:0]         r_val, h_val;

    // stage 1: products
    logic signed [PW-1:0]   prd_reg [3][3], prd_next [3][3];
    logic signed [PW-1:0]   pcr_reg [3][2], pcr_next [3][2];
    logic signed [2*W-1:0]  puu_reg [3], puu_next [3];
    logic signed [2*DW-1:0] pdd_reg [3], pdd_next [3];
    logic [RRW-1:0]         rr1_reg, rr1_next;
    // stage 2: sums
    logic signed [SW-1:0]   e_reg [3], e_next [3];
    logic signed [CW-1:0]   cr_reg [3], cr_next [3];
    logic [UUW-1:0]         uu_reg, uu_next;
    logic [DDW-1:0]         dd_reg, dd_next;
    logic [RRW-1:0]         rr2_reg;
    // stage 3: compares and split products
    logic                   box3_reg, box3_next, sph3_reg, sph3_next;
    logic [LW-1:0]          lhs3_reg, lhs3_next;
    logic [2*CHI-1:0]       pa_reg [3], pa_next [3];
    logic [CHI+CLO-1:0]     pab_reg [3], pab_next [3];
    logic [2*CLO-1:0]       pb_reg [3], pb_next [3];
    logic [W+UHW-1:0]       hh_reg, hh_next, lh_reg, lh_next, huh_reg, huh_next;
    logic [2*W-1:0]         hl_reg, hl_next, ll_reg, ll_next, hul_reg, hul_next;
    // stage 4: wide sums
    logic                   box4_reg, sph4_reg;
    logic [LW-1:0]          lhs4_reg;
    logic [AW-1:0]          acc_reg, acc_next;
    logic [BBW-1:0]         bb_reg, bb_next;
    logic [HW-1:0]          rhs_reg, rhs_next;

    assign en  = !out_v_reg || res.ready;
    assign pop = en && !empty;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            d[i] = $signed(head[i]);
            for (int j = 0; j < 3; j++)
            begin
                rot[i][j] = $signed(cfg.rot[i][j*W +: W]);
            end
        end
        r_val = cfg.rh[W-1:0];
        h_val = cfg.rh[2*W-1:W];
    end

    // stage 1
    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                prd_next[j][i] = PW'(rot[j][i]) * PW'(d[j]);
            end
            puu_next[j] = (2*W)'(rot[j][1]) * (2*W)'(rot[j][1]);
            pdd_next[j] = (2*DW)'(d[j]) * (2*DW)'(d[j]);
        end
        // cross product terms of delta with the axis (column 1)
        pcr_next[0][0] = PW'(d[1]) * PW'(rot[2][1]);
        pcr_next[0][1] = PW'(d[2]) * PW'(rot[1][1]);
        pcr_next[1][0] = PW'(d[2]) * PW'(rot[0][1]);
        pcr_next[1][1] = PW'(d[0]) * PW'(rot[2][1]);
        pcr_next[2][0] = PW'(d[0]) * PW'(rot[1][1]);
        pcr_next[2][1] = PW'(d[1]) * PW'(rot[0][1]);
        rr1_next = RRW'(r_val) * RRW'(r_val);
    end

    // stage 2
    always_comb
    begin
        uu_next = '0;
        dd_next = '0;
        for (int i = 0; i < 3; i++)
        begin
            e_next[i]  = SW'(prd_reg[0][i]) + SW'(prd_reg[1][i]) + SW'(prd_reg[2][i]);
            cr_next[i] = CW'(pcr_reg[i][0]) - CW'(pcr_reg[i][1]);
            uu_next    = uu_next + UUW'(puu_reg[i][UQW-1:0]);
            dd_next    = dd_next + DDW'(pdd_reg[i][DQW-1:0]);
        end
    end

    // stage 3
    logic [MW-1:0]          crm [3];
    logic signed [SW-1:0]   along_neg;
    logic [SW-2:0]          amag;
    logic signed [SW:0]     e2, lim;
    always_comb
    begin
        box3_next = 1'b1;
        for (int i = 0; i < 3; i++)
        begin
            e2  = {e_reg[i], 1'b0};
            lim = (SW+1)'(LIMW'(cfg.extent[i*W +: W]) << ROT_FRAC_BITS);
            if (e2 < -lim || e2 > lim)
            begin
                box3_next = 1'b0;
            end
            crm[i]      = cr_reg[i][CW-1] ? MW'(-cr_reg[i]) : MW'(cr_reg[i]);
            pa_next[i]  = (2*CHI)'(crm[i][MW-1:CLO]) * (2*CHI)'(crm[i][MW-1:CLO]);
            pab_next[i] = (CHI+CLO)'(crm[i][MW-1:CLO]) * (CHI+CLO)'(crm[i][CLO-1:0]);
            pb_next[i]  = (2*CLO)'(crm[i][CLO-1:0]) * (2*CLO)'(crm[i][CLO-1:0]);
        end
        sph3_next = dd_reg <= DDW'(rr2_reg);
        // along-axis component is e[1]
        along_neg = -e_reg[1];
        amag      = e_reg[1][SW-1] ? along_neg[SW-2:0] : e_reg[1][SW-2:0];
        lhs3_next = LW'(amag) << (ROT_FRAC_BITS + 1);
        hh_next   = (W+UHW)'(rr2_reg[RRW-1:W]) * (W+UHW)'(uu_reg[UUW-1:W]);
        lh_next   = (W+UHW)'(rr2_reg[W-1:0]) * (W+UHW)'(uu_reg[UUW-1:W]);
        hl_next   = (2*W)'(rr2_reg[RRW-1:W]) * (2*W)'(uu_reg[W-1:0]);
        ll_next   = (2*W)'(rr2_reg[W-1:0]) * (2*W)'(uu_reg[W-1:0]);
        huh_next  = (W+UHW)'(h_val) * (W+UHW)'(uu_reg[UUW-1:W]);
        hul_next  = (2*W)'(h_val) * (2*W)'(uu_reg[W-1:0]);
    end

    // stage 4
    always_comb
    begin
        acc_next = '0;
        for (int i = 0; i < 3; i++)
        begin
            acc_next = acc_next + (AW'(pa_reg[i]) << (2 * CLO))
                     + (AW'(pab_reg[i]) << (CLO + 1)) + AW'(pb_reg[i]);
        end
        bb_next  = (BBW'(hh_reg) << (2 * W))
                 + ((BBW'(hl_reg) + BBW'(lh_reg)) << W) + BBW'(ll_reg);
        rhs_next = HW'(hul_reg) + (HW'(huh_reg) << W);
    end

    // final select
    always_comb
    begin
        case (cfg.shape)
            SHAPE_BOX:    out_in_next = box4_reg;
            SHAPE_CYL:    out_in_next = (lhs4_reg < LW'(rhs_reg)) && (acc_reg < AW'(bb_reg));
            SHAPE_SPHERE: out_in_next = sph4_reg;
            default:      out_in_next = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            v4_reg    <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg    <= !empty;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            v4_reg    <= v3_reg;
            out_v_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prd_reg    <= prd_next;
            pcr_reg    <= pcr_next;
            puu_reg    <= puu_next;
            pdd_reg    <= pdd_next;
            rr1_reg    <= rr1_next;
            e_reg      <= e_next;
            cr_reg     <= cr_next;
            uu_reg     <= uu_next;
            dd_reg     <= dd_next;
            rr2_reg    <= rr1_reg;
            box3_reg   <= box3_next;
            sph3_reg   <= sph3_next;
            lhs3_reg   <= lhs3_next;
            pa_reg     <= pa_next;
            pab_reg    <= pab_next;
            pb_reg     <= pb_next;
            hh_reg     <= hh_next;
            lh_reg     <= lh_next;
            hl_reg     <= hl_next;
            ll_reg     <= ll_next;
            huh_reg    <= huh_next;
            hul_reg    <= hul_next;
            box4_reg   <= box3_reg;
            sph4_reg   <= sph3_reg;
            lhs4_reg   <= lhs3_reg;
            acc_reg    <= acc_next;
            bb_reg     <= bb_next;
            rhs_reg    <= rhs_next;
            out_in_reg <= out_in_next;
        end
    end

    assign res.valid      = out_v_reg;
    assign res.inside_res = out_in_reg;

endmodule
